@@ src/box_blur_window_mean_defines.svh @@
// Assertion macros for the box blur block.
// Expect clk and rst in the scope of each use; no other dependencies.
`ifndef BOX_BLUR_WINDOW_MEAN_DEFINES_SVH
`define BOX_BLUR_WINDOW_MEAN_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBWM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbwm: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BBWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbwm: assertion failed");

`endif

@@ src/bbwm_pkg.sv @@
// Shared types and constants for the box blur block.
// No dependencies; used by the channel interfaces and the top level.
package bbwm_pkg;

  localparam int COORD_W   = 8;
  localparam int CH_W      = 8;
  localparam int DIM_W     = 9;
  localparam int RAD_W     = 4;
  localparam int EXT_W     = 5;   // window extent, at most twice the radius
  localparam int CNT_W     = 10;  // pixel count, at most 30*30
  localparam int SUM_W     = 18;  // channel sum, at most 900*255
  localparam int DIVC_W    = 5;   // counts quotient bits
  localparam int PIX_W     = 3 * CH_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;

  localparam logic [DIM_W-1:0] RESET_DIM    = 9'd256;
  localparam logic [RAD_W-1:0] RESET_RADIUS = 4'd5;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

@@ src/bbwm_req_if.sv @@
// Request channel of the box blur: load or query word with valid/ready.
// Depends on bbwm_pkg for field widths.
interface bbwm_req_if import bbwm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [CH_W-1:0]    red_in;
  logic [CH_W-1:0]    green_in;
  logic [CH_W-1:0]    blue_in;

  modport source (output valid, func, col, row, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, func, col, row, red_in, green_in, blue_in, output ready);
endinterface

@@ src/bbwm_rsp_if.sv @@
// Response channel of the box blur: averaged pixel word with valid/ready.
// Depends on bbwm_pkg for field widths.
interface bbwm_rsp_if import bbwm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic            empty_window;

  modport source (output valid, red_out, green_out, blue_out, empty_window, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, empty_window, output ready);
endinterface

@@ src/box_blur_window_mean.sv @@
// Box blur top level: frame store, window scan, accumulate and divide.
// Depends on bbwm_pkg, bbwm_req_if, bbwm_rsp_if and the assertion macro header.
//
// A load word writes one RGB888 pixel into an on-chip frame store of
// MAX_WIDTH*MAX_HEIGHT entries in the cycle it is accepted (loads outside the
// store are dropped). A query word averages each channel over the clipped,
// half-open window [col-r, min(col+r, W-1)) x [row-r, min(row+r, H-1)) and
// returns one response word. The scan reads the N pixels of the window (up to
// (2*radius)^2, 100 at the default radius) through the single read port of the
// frame store, one pixel per cycle; then an 18-step restoring divider produces
// all three channel means in parallel. A query with an empty window skips the
// scan and answers black. The result sits in an output register, so the next
// word is taken while it waits. The store is not cleared at reset; query only
// pixels that have been loaded. Configuration must be written only while the
// block is idle; the block itself does not enforce this.
`include "box_blur_window_mean_defines.svh"

module box_blur_window_mean import bbwm_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  bbwm_req_if.sink             req,
  bbwm_rsp_if.source           rsp
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // Configuration
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [RAD_W-1:0] radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_DIM;
      image_height <= RESET_DIM;
      radius       <= RESET_RADIUS;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        REG_RADIUS: radius       <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  // Window bounds from the incoming word
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [COORD_W-1:0] bx0, by0;
  logic [DIM_W-1:0]   bx1, by1, xs, ys, wm1, hm1;
  logic               win_empty;
  logic [EXT_W-1:0]   ext_x, ext_y;

  always_comb begin
    w_eff = (32'(image_width) < MAX_WIDTH) ? image_width : DIM_W'(MAX_WIDTH);
    h_eff = (32'(image_height) < MAX_HEIGHT) ? image_height : DIM_W'(MAX_HEIGHT);
    bx0   = (req.col >= COORD_W'(radius)) ? req.col - COORD_W'(radius) : '0;
    by0   = (req.row >= COORD_W'(radius)) ? req.row - COORD_W'(radius) : '0;
    xs    = {1'b0, req.col} + DIM_W'(radius);
    ys    = {1'b0, req.row} + DIM_W'(radius);
    wm1   = w_eff - 1'b1;
    hm1   = h_eff - 1'b1;
    bx1   = (xs < wm1) ? xs : wm1;
    by1   = (ys < hm1) ? ys : hm1;
    win_empty = (w_eff == '0) || (h_eff == '0)
             || (bx1 <= {1'b0, bx0}) || (by1 <= {1'b0, by0});
    ext_x = EXT_W'(bx1 - {1'b0, bx0});
    ext_y = EXT_W'(by1 - {1'b0, by0});
  end

  // Query registers
  logic [COORD_W-1:0] x0, x, y;
  logic [DIM_W-1:0]   x1, y1;
  logic [CNT_W-1:0]   count;
  logic               empty;
  logic               rd_pend;
  logic [DIVC_W-1:0]  div_cnt;

  logic accept, load_acc, query_acc, scan_last, finish;
  logic scan_rd, div_run;

  assign accept    = req.valid && req.ready;
  assign load_acc  = accept && (req.func == FUNC_LOAD);
  assign query_acc = accept && (req.func == FUNC_QUERY);
  assign scan_last = ((DIM_W'(x) + 1'b1) == x1) && ((DIM_W'(y) + 1'b1) == y1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (query_acc) state_next = win_empty ? ST_DONE : ST_SCAN;
      ST_SCAN:  if (scan_last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DIV;
      ST_DIV:   if (div_cnt == '0) state_next = ST_DONE;
      ST_DONE:  if (finish) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    req.ready = (state == ST_IDLE);
    scan_rd   = (state == ST_SCAN);
    div_run   = (state == ST_DIV);
    finish    = (state == ST_DONE) && (!rsp.valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Frame store: one write port, one registered read port
  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             wr_ok;

  assign wr_ok   = (32'(req.col) < MAX_WIDTH) && (32'(req.row) < MAX_HEIGHT);
  assign wr_addr = AW'(32'(req.row) * MAX_WIDTH + 32'(req.col));
  assign rd_addr = AW'(32'(y) * MAX_WIDTH + 32'(x));

  always_ff @(posedge clk) begin
    if (load_acc && wr_ok) mem[wr_addr] <= {req.red_in, req.green_in, req.blue_in};
    if (scan_rd) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) rd_pend <= 1'b0;
    else     rd_pend <= scan_rd;
  end

  // Scan counters
  always_ff @(posedge clk) begin
    if (query_acc) begin
      x0    <= bx0;
      x     <= bx0;
      y     <= by0;
      x1    <= bx1;
      y1    <= by1;
      count <= CNT_W'(ext_x) * CNT_W'(ext_y);
      empty <= win_empty;
    end else if (scan_rd) begin
      if ((DIM_W'(x) + 1'b1) == x1) begin
        x <= x0;
        y <= y + 1'b1;
      end else begin
        x <= x + 1'b1;
      end
    end
  end

  // Per-channel accumulator, reused as dividend/quotient shift register
  logic [SUM_W-1:0] acc     [3];
  logic [CNT_W-1:0] rem     [3];
  logic [CNT_W:0]   rem_sh  [3];
  logic [CNT_W:0]   rem_sub [3];
  logic             q_bit   [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rem_sh[c]  = {rem[c], acc[c][SUM_W-1]};
      q_bit[c]   = (rem_sh[c] >= {1'b0, count});
      rem_sub[c] = rem_sh[c] - {1'b0, count};
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DRAIN) div_cnt <= DIVC_W'(SUM_W - 1);
    else if (div_run)      div_cnt <= div_cnt - 1'b1;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (query_acc) begin
        acc[c] <= '0;
      end else if (rd_pend) begin
        acc[c] <= acc[c] + SUM_W'(rd_data[PIX_W-1-CH_W*c -: CH_W]);
      end else if (div_run) begin
        acc[c] <= {acc[c][SUM_W-2:0], q_bit[c]};
      end
      if (state == ST_DRAIN) begin
        rem[c] <= '0;
      end else if (div_run) begin
        rem[c] <= q_bit[c] ? CNT_W'(rem_sub[c]) : CNT_W'(rem_sh[c]);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (finish) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.red_out      <= empty ? '0 : acc[0][CH_W-1:0];
      rsp.green_out    <= empty ? '0 : acc[1][CH_W-1:0];
      rsp.blue_out     <= empty ? '0 : acc[2][CH_W-1:0];
      rsp.empty_window <= empty;
    end
  end

  // Scan stays inside the window
  `BBWM_ASSERT_SAME(a_scan_in_window, scan_rd, (DIM_W'(x) < x1) && (DIM_W'(y) < y1) && (x >= x0))
  // Read data is only consumed the cycle after a scan read
  `BBWM_ASSERT_SAME(a_rd_after_scan, rd_pend, $past(state) == ST_SCAN)
  // A non-empty query always starts a scan
  `BBWM_ASSERT_NEXT(a_query_scans, query_acc && !win_empty, state == ST_SCAN)
  // Finishing a query raises the response
  `BBWM_ASSERT_NEXT(a_finish_valid, finish, rsp.valid && (state == ST_IDLE))

endmodule
